// ===== design/swfr_pkg.sv =====
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared constants and helper functions of the sync-word frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 19;

  localparam int unsigned IDLE_W      = 17;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [23:0]          SYNC_WORD     = 24'h550100;
  localparam logic [BYTE_W-1:0]    SYNC_B0       = 8'h55;
  localparam logic [BYTE_W-1:0]    SYNC_B1       = 8'h01;
  localparam logic [BYTE_W-1:0]    SYNC_B2       = 8'h00;

  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_DISCARD = 1'b1;

  function automatic logic is_sync_byte(input logic [BYTE_W-1:0] b);
    return (b == SYNC_B0) || (b == SYNC_B1) || (b == SYNC_B2);
  endfunction

  function automatic logic [BYTE_W-1:0] header_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] r;
    unique case (pos)
      2'd0:    r = SYNC_B0;
      2'd1:    r = SYNC_B1;
      default: r = SYNC_B2;
    endcase
    return r;
  endfunction

endpackage

// ===== design/sync_word_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_word_frame_receiver
// Sync-word byte deframer with idle timeout; frame bytes held in a RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser | tlast
//  s_axis   | in  | rx_byte[7:0]                                | op    | -
//  m_axis   | out | byte_index[4:0] packet_byte[7:0]            | kind  | last
//           |     | discard_length[4:0], zero pad[5:0]          |       |
//  timeout  | in  | timeout_wdata_i[15:0] when timeout_we_i     | -     | -
//
//  A byte or tick item is taken when the output register is free and no frame
//  is being sent. A completed frame is sent as FRAME_BYTES items, each from a RAM
//  read state and then an output load state; input is held off meanwhile.
//  Output stalls hold the output register and back up into the input.
//  Reset is asynchronous, active low; the frame RAM is not cleared.
// ----------------------------------------------------------------------------
module sync_word_frame_receiver #(
  parameter int unsigned FRAME_BYTES = swfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             timeout_we_i,
  input  logic [swfr_pkg::TIMEOUT_W-1:0]   timeout_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [swfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // rx_byte
  input  logic                             s_axis_tuser_i,   // op
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [swfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // byte_index, packet_byte,
                                                             // discard_length
  output logic                             m_axis_tuser_o,   // kind
  output logic                             m_axis_tlast_o    // last
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned BW = swfr_pkg::BYTE_W;
  localparam int unsigned XW = swfr_pkg::IDX_W;
  localparam int unsigned IW = swfr_pkg::IDLE_W;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e                          state_q, state_d;
  logic [swfr_pkg::TIMEOUT_W-1:0]  timeout_q, timeout_d;
  logic                            collecting_q, collecting_d;
  logic [23:0]                     window_q, window_d;
  logic [CW-1:0]                   fill_q, fill_d;
  logic [IW-1:0]                   idle_q, idle_d;
  logic [AW-1:0]                   ptr_q, ptr_d;

  logic                            ovalid_q, ovalid_d;
  logic                            okind_q, okind_d;
  logic [XW-1:0]                   oidx_q, oidx_d;
  logic [BW-1:0]                   obyte_q, obyte_d;
  logic [XW-1:0]                   odlen_q, odlen_d;
  logic                            olast_q, olast_d;

  logic                            out_free;
  logic                            in_acc;
  logic [BW-1:0]                   rx_byte;
  logic [IW-1:0]                   idle_inc;
  logic [23:0]                     window_sh;
  logic [CW-1:0]                   fill_inc;
  logic [AW+XW-1:0]                ptr_ext;
  logic [CW+XW-1:0]                fill_ext;
  logic                            mem_we;
  logic                            mem_re;
  logic [BW-1:0]                   mem_rdata;

  assign out_free        = !ovalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_RUN) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign rx_byte         = s_axis_tdata_i;
  assign idle_inc        = (idle_q == {IW{1'b1}}) ? idle_q : idle_q + IW'(1);
  assign window_sh       = {window_q[15:0], rx_byte};
  assign fill_inc        = fill_q + CW'(1);
  assign ptr_ext         = (AW + XW)'(ptr_q);
  assign fill_ext        = (CW + XW)'(fill_q);
  assign mem_we          = in_acc && (s_axis_tuser_i == swfr_pkg::OP_BYTE) && collecting_q;
  assign mem_re          = (state_q == ST_READ);

  swfr_frame_mem #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (rx_byte),
    .re_i    (mem_re),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    timeout_d    = timeout_q;
    collecting_d = collecting_q;
    window_d     = window_q;
    fill_d       = fill_q;
    idle_d       = idle_q;
    ptr_d        = ptr_q;
    ovalid_d     = ovalid_q && !m_axis_tready_i;
    okind_d      = okind_q;
    oidx_d       = oidx_q;
    obyte_d      = obyte_q;
    odlen_d      = odlen_q;
    olast_d      = olast_q;

    if (timeout_we_i) begin
      timeout_d = timeout_wdata_i;
    end

    unique case (state_q)
      ST_RUN: begin
        if (in_acc) begin
          if (s_axis_tuser_i == swfr_pkg::OP_TICK) begin
            idle_d = idle_inc;
            if (collecting_q && (idle_inc > IW'(timeout_q))) begin
              ovalid_d     = 1'b1;
              okind_d      = swfr_pkg::KIND_DISCARD;
              oidx_d       = '0;
              obyte_d      = '0;
              odlen_d      = fill_ext[XW-1:0];
              olast_d      = 1'b1;
              collecting_d = 1'b0;
              fill_d       = '0;
            end
          end else begin
            idle_d = '0;
            if (!collecting_q) begin
              if (!swfr_pkg::is_sync_byte(rx_byte)) begin
                fill_d = '0;
              end else begin
                window_d = window_sh;
                if (window_sh == swfr_pkg::SYNC_WORD) begin
                  fill_d       = CW'(3);
                  collecting_d = 1'b1;
                end
              end
            end else if (fill_inc >= CW'(FRAME_BYTES)) begin
              collecting_d = 1'b0;
              fill_d       = '0;
              ptr_d        = '0;
              state_d      = ST_READ;
            end else begin
              fill_d = fill_inc;
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = swfr_pkg::KIND_BYTE;
          oidx_d   = ptr_ext[XW-1:0];
          obyte_d  = (ptr_q < AW'(3)) ? swfr_pkg::header_byte(ptr_q[1:0]) : mem_rdata;
          odlen_d  = '0;
          olast_d  = (ptr_q == AW'(FRAME_BYTES - 1));
          if (ptr_q == AW'(FRAME_BYTES - 1)) begin
            state_d = ST_RUN;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      timeout_q    <= swfr_pkg::TIMEOUT_RESET;
      collecting_q <= 1'b0;
      window_q     <= '0;
      fill_q       <= '0;
      idle_q       <= '0;
      ptr_q        <= '0;
      ovalid_q     <= 1'b0;
      okind_q      <= 1'b0;
      oidx_q       <= '0;
      obyte_q      <= '0;
      odlen_q      <= '0;
      olast_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      timeout_q    <= timeout_d;
      collecting_q <= collecting_d;
      window_q     <= window_d;
      fill_q       <= fill_d;
      idle_q       <= idle_d;
      ptr_q        <= ptr_d;
      ovalid_q     <= ovalid_d;
      okind_q      <= okind_d;
      oidx_q       <= oidx_d;
      obyte_q      <= obyte_d;
      odlen_q      <= odlen_d;
      olast_q      <= olast_d;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {6'd0, odlen_q, obyte_q, oidx_q};

endmodule

// ===== design/swfr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// swfr_frame_mem
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swfr_frame_mem #(
  parameter int unsigned DEPTH = swfr_pkg::FRAME_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [swfr_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [swfr_pkg::BYTE_W-1:0] rdata_o
);

  logic [swfr_pkg::BYTE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
